// File: hw/rtl/i2cms_pkg.sv
// shared types, codes and defaults of the i2c master message sequencer
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int MaxMsgsDefault  = 8;
  localparam int BufBytesDefault = 256;

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpWrite   = 2'd1,
    OpEnqueue = 2'd2,
    OpEvent   = 2'd3
  } op_e;

  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRepStart   = 8'h10;
  localparam logic [7:0] StMtSlaAck   = 8'h18;
  localparam logic [7:0] StMtSlaNack  = 8'h20;
  localparam logic [7:0] StMtDataAck  = 8'h28;
  localparam logic [7:0] StMtDataNack = 8'h30;
  localparam logic [7:0] StMrSlaAck   = 8'h40;
  localparam logic [7:0] StMrSlaNack  = 8'h48;
  localparam logic [7:0] StMrDataAck  = 8'h50;
  localparam logic [7:0] StMrDataNack = 8'h58;

  localparam logic [1:0] ChainOk   = 2'd0;
  localparam logic [1:0] ChainNack = 2'd1;
  localparam logic [1:0] ChainWcol = 2'd2;

  localparam logic [1:0] EnqAccepted = 2'd0;
  localparam logic [1:0] EnqBusy     = 2'd1;
  localparam logic [1:0] EnqDisabled = 2'd2;

  typedef struct packed {
    logic       write_collision;
    logic [7:0] rx_byte;
    logic [7:0] bus_status;
    logic [3:0] msg_count;
    logic [7:0] buf_byte;
    logic [7:0] buf_index;
    logic [7:0] msg_offset;
    logic [7:0] msg_length;
    logic [7:0] addr_byte;
    logic [2:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pad;
    logic [1:0] enqueue_result;
    logic [1:0] chain_status;
    logic       idle;
    logic [7:0] rx_store_index;
    logic       rx_store_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       ack_next;
    logic       send_stop;
    logic       send_start;
  } out_item_t;

endpackage

// File: hw/rtl/i2cms_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module i2cms_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/i2c_master_message_sequencer.sv
// i2c master message sequencer top level
//
// usage: descriptors (address byte, length, offset) and buffer bytes are
// loaded through the slave stream, tuser selects the operation. an enqueue
// request starts a chain from slot 0; every later bus status event request
// yields the next bus action (start, stop, byte to send, ack, stored byte).
// every request accepted on s_axis gives exactly one result on m_axis.
// cfg channel writes bus_enable, always ready; the user must write it only while
// the block is idle, the block itself does not enforce this. path: a request
// is worked out by the decode logic from the input register and its result
// is registered in the result register, from which m_axis takes it.
// throughput: one request per cycle while m_axis_tready is high, set by the
// single decode stage; the buffer ram is read at the next pointer each cycle
// and a same cycle write is forwarded.
// reset: chain idle, status success, bus disabled; descriptor and buffer
// contents are undefined until written.
// stall: while m_axis_tready is low the result holds and one more request
// is taken into the input register, then s_axis_tready drops.
`timescale 1ns / 1ps

module i2c_master_message_sequencer #(
  parameter int MaxMsgs  = i2cms_pkg::MaxMsgsDefault,
  parameter int BufBytes = i2cms_pkg::BufBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot, addr_byte, msg_length, msg_offset, buf_index, buf_byte, msg_count,
  // bus_status, rx_byte, write_collision
  input  logic [63:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // send_start, send_stop, ack_next, tx_valid, tx_byte, rx_store_valid,
  // rx_store_index, idle, chain_status, enqueue_result, zero pad
  output logic [31:0] m_axis_tdata
);

  localparam int SlotW = (MaxMsgs > 1) ? $clog2(MaxMsgs) : 1;
  localparam int MsgW  = $clog2(MaxMsgs + 1);
  localparam int AddrW = (BufBytes > 1) ? $clog2(BufBytes) : 1;

  function automatic logic [AddrW-1:0] buf_wrap(input logic [7:0] ptr);
    logic [11:0] v;
    v = {4'd0, ptr};
    for (int k = 3; k >= 0; k--) begin
      if (v >= 12'(BufBytes << k)) begin
        v = v - 12'(BufBytes << k);
      end
    end
    return v[AddrW-1:0];
  endfunction

  // configuration
  logic bus_enable_q;
  assign cfg_ready_o = 1'b1;

  // input register
  logic                item_valid_q;
  i2cms_pkg::in_item_t item_q;
  logic [1:0]          s_axis_tuser_q;
  i2cms_pkg::op_e      op_q;
  logic                exec;

  // result register
  logic                 out_valid_q;
  i2cms_pkg::out_item_t out_q;
  i2cms_pkg::out_item_t res;

  // chain state
  logic [SlotW-1:0] cur_slot_q, cur_slot_d;
  logic [MsgW-1:0]  msgs_left_q, msgs_left_d;
  logic [7:0]       bytes_left_q, bytes_left_d;
  logic [7:0]       buf_ptr_q, buf_ptr_d;
  logic             idle_q, idle_d;
  logic [1:0]       status_q, status_d;

  // descriptor table
  logic [7:0] desc_addr_q [MaxMsgs];
  logic [7:0] desc_len_q  [MaxMsgs];
  logic [7:0] desc_off_q  [MaxMsgs];
  logic       desc_we;
  logic [SlotW-1:0] desc_widx;

  // buffer ram
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;
  logic [7:0]       buf_rd;
  logic [AddrW-1:0] ptr_at;

  logic [SlotW-1:0] slot_next;
  logic [SlotW-1:0] begin_slot;
  logic [7:0]       bl_dec;
  logic [MsgW-1:0]  ml_dec;
  logic [3:0]       cnt_fix;
  logic             do_finish;
  logic             do_store;

  assign op_q          = i2cms_pkg::op_e'(s_axis_tuser_q);

  assign exec          = item_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !item_valid_q || exec;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign slot_next  = (cur_slot_q == SlotW'(MaxMsgs - 1)) ? '0 : cur_slot_q + 1'b1;
  assign begin_slot = (op_q == i2cms_pkg::OpEnqueue) ? '0 : slot_next;
  assign bl_dec     = (bytes_left_q == 8'd0) ? 8'd0 : bytes_left_q - 8'd1;
  assign ml_dec     = (msgs_left_q == '0) ? '0 : msgs_left_q - 1'b1;
  assign cnt_fix    = (item_q.msg_count == 4'd0) ? 4'd1 : item_q.msg_count;
  assign ptr_at     = buf_wrap(buf_ptr_q);
  assign buf_rd     = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign desc_widx  = SlotW'(item_q.slot);

  always_comb begin
    res          = '0;
    cur_slot_d   = cur_slot_q;
    msgs_left_d  = msgs_left_q;
    bytes_left_d = bytes_left_q;
    buf_ptr_d    = buf_ptr_q;
    idle_d       = idle_q;
    status_d     = status_q;
    desc_we      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = ptr_at;
    ram_wdata    = item_q.rx_byte;
    do_finish    = 1'b0;
    do_store     = 1'b0;
    if (exec) begin
      case (op_q)
        i2cms_pkg::OpLoad: begin
          desc_we = (int'(item_q.slot) < MaxMsgs);
        end
        i2cms_pkg::OpWrite: begin
          ram_we    = (int'(item_q.buf_index) < BufBytes);
          ram_waddr = AddrW'(item_q.buf_index);
          ram_wdata = item_q.buf_byte;
        end
        i2cms_pkg::OpEnqueue: begin
          if (!bus_enable_q) begin
            res.enqueue_result = i2cms_pkg::EnqDisabled;
          end else if (!idle_q) begin
            res.enqueue_result = i2cms_pkg::EnqBusy;
          end else begin
            res.enqueue_result = i2cms_pkg::EnqAccepted;
            msgs_left_d  = (int'(cnt_fix) > MaxMsgs) ? MsgW'(MaxMsgs) : MsgW'(cnt_fix);
            cur_slot_d   = '0;
            bytes_left_d = desc_len_q[begin_slot];
            buf_ptr_d    = desc_off_q[begin_slot];
            idle_d       = 1'b0;
            status_d     = i2cms_pkg::ChainOk;
            res.send_start = 1'b1;
          end
        end
        i2cms_pkg::OpEvent: begin
          if (!idle_q) begin
            if (item_q.write_collision) begin
              status_d = i2cms_pkg::ChainWcol;
              idle_d   = 1'b1;
            end else begin
              case (item_q.bus_status)
                i2cms_pkg::StStart, i2cms_pkg::StRepStart: begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = desc_addr_q[cur_slot_q];
                end
                i2cms_pkg::StMtSlaAck, i2cms_pkg::StMtDataAck: begin
                  if (bytes_left_q == 8'd0) begin
                    do_finish = 1'b1;
                  end else begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = buf_rd;
                    buf_ptr_d    = buf_ptr_q + 8'd1;
                    bytes_left_d = bytes_left_q - 8'd1;
                  end
                end
                i2cms_pkg::StMrSlaAck: begin
                  res.ack_next = (bytes_left_q > 8'd1);
                end
                i2cms_pkg::StMrDataAck: begin
                  do_store = 1'b1;
                  if (bl_dec > 8'd1) begin
                    res.ack_next = 1'b1;
                  end else if (bl_dec == 8'd0) begin
                    do_finish = 1'b1;
                  end
                end
                i2cms_pkg::StMrDataNack: begin
                  do_store  = 1'b1;
                  do_finish = 1'b1;
                end
                i2cms_pkg::StMtSlaNack, i2cms_pkg::StMrSlaNack,
                i2cms_pkg::StMtDataNack: begin
                  status_d      = i2cms_pkg::ChainNack;
                  res.send_stop = 1'b1;
                  idle_d        = 1'b1;
                end
                default: begin
                  res.send_stop = 1'b1;
                  idle_d        = 1'b1;
                end
              endcase
            end
          end
        end
        default: ;
      endcase

      if (do_store) begin
        ram_we             = 1'b1;
        ram_waddr          = ptr_at;
        ram_wdata          = item_q.rx_byte;
        res.rx_store_valid = 1'b1;
        res.rx_store_index = 8'(ptr_at);
        buf_ptr_d          = buf_ptr_q + 8'd1;
        bytes_left_d       = bl_dec;
      end

      if (do_finish) begin
        msgs_left_d = ml_dec;
        if (ml_dec != '0) begin
          cur_slot_d     = slot_next;
          bytes_left_d   = desc_len_q[begin_slot];
          buf_ptr_d      = desc_off_q[begin_slot];
          res.send_start = 1'b1;
        end else begin
          res.send_stop = 1'b1;
          status_d      = i2cms_pkg::ChainOk;
          idle_d        = 1'b1;
        end
      end
    end
    res.idle         = idle_d;
    res.chain_status = status_d;
  end

  assign ram_raddr = buf_wrap(buf_ptr_d);

  i2cms_ram #(
    .Width(8),
    .Depth(BufBytes)
  ) u_buf_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_enable_q <= 1'b0;
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cur_slot_q   <= '0;
      msgs_left_q  <= '0;
      bytes_left_q <= 8'd0;
      buf_ptr_q    <= 8'd0;
      idle_q       <= 1'b1;
      status_q     <= i2cms_pkg::ChainOk;
      fwd_hit_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        bus_enable_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      cur_slot_q   <= cur_slot_d;
      msgs_left_q  <= msgs_left_d;
      bytes_left_q <= bytes_left_d;
      buf_ptr_q    <= buf_ptr_d;
      idle_q       <= idle_d;
      status_q     <= status_d;
      fwd_hit_q    <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q         <= i2cms_pkg::in_item_t'(s_axis_tdata);
      s_axis_tuser_q <= s_axis_tuser;
    end
    if (exec) begin
      out_q <= res;
    end
    fwd_data_q <= ram_wdata;
    if (desc_we) begin
      desc_addr_q[desc_widx] <= item_q.addr_byte;
      desc_len_q[desc_widx]  <= item_q.msg_length;
      desc_off_q[desc_widx]  <= item_q.msg_offset;
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !out_valid_q |=> out_valid_q)
    else $error("pending request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.send_start |-> !out_q.idle)
    else $error("start requested while chain reports idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.tx_valid |-> out_q.tx_byte == 8'd0)
    else $error("tx byte set without tx valid");

endmodule

// File: dv/tb_i2c_master_message_sequencer.sv
// testbench of the i2c master message sequencer: directed table, random chains, predictor
`timescale 1ns / 1ps

module tb_i2c_master_message_sequencer;
  import i2cms_pkg::*;

  typedef enum logic [1:0] {
    BsStart,
    BsAddr,
    BsData,
    BsRx
  } bus_step_e;

  typedef struct packed {
    logic      en;
    op_e       op;
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  // predictor copy of the sequencer state
  logic [7:0]  tbl_addr [MaxMsgsDefault];
  logic [7:0]  tbl_len  [MaxMsgsDefault];
  logic [7:0]  tbl_off  [MaxMsgsDefault];
  logic [7:0]  mem_buf  [BufBytesDefault];
  bit          tbl_set  [MaxMsgsDefault];
  bit          buf_set  [BufBytesDefault];
  logic [2:0]  slot_q = '0;
  logic [3:0]  msgs_rem = '0;
  logic [7:0]  bytes_rem = '0;
  logic [7:0]  buf_pos = '0;
  logic        chain_idle = 1'b1;
  logic [1:0]  chain_st = ChainOk;
  logic        bus_en = 1'b0;
  out_item_t   act;

  out_item_t   pending_actions [$];
  plan_row_t   plan [$];
  int          mismatches = 0;
  int          stim_count = 0;
  int          src_gap = 12;
  int          sink_gap = 81;
  bus_step_e   bus_step = BsStart;
  logic        rd_mode = 1'b0;

  always #1 clk_i = ~clk_i;

  i2c_master_message_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic void open_msg();
    bytes_rem = tbl_len[slot_q];
    buf_pos   = tbl_off[slot_q];
  endfunction

  function automatic void close_msg();
    if (msgs_rem != 0) msgs_rem = msgs_rem - 4'd1;
    if (msgs_rem != 0) begin
      slot_q = slot_q + 3'd1;
      open_msg();
      act.send_start = 1'b1;
    end else begin
      act.send_stop = 1'b1;
      chain_st      = ChainOk;
      chain_idle    = 1'b1;
    end
  endfunction

  function automatic void keep_rx(logic [7:0] rx);
    mem_buf[buf_pos]   = rx;
    buf_set[buf_pos]   = 1'b1;
    act.rx_store_valid = 1'b1;
    act.rx_store_index = buf_pos;
    buf_pos            = buf_pos + 8'd1;
    if (bytes_rem != 0) bytes_rem = bytes_rem - 8'd1;
  endfunction

  function automatic void take_bus_event(in_item_t d);
    if (chain_idle) return;
    if (d.write_collision) begin
      chain_st   = ChainWcol;
      chain_idle = 1'b1;
      return;
    end
    case (d.bus_status)
      StStart, StRepStart: begin
        act.tx_valid = 1'b1;
        act.tx_byte  = tbl_addr[slot_q];
      end
      StMtSlaAck, StMtDataAck: begin
        if (bytes_rem == 0) begin
          close_msg();
        end else begin
          act.tx_valid = 1'b1;
          act.tx_byte  = mem_buf[buf_pos];
          buf_pos      = buf_pos + 8'd1;
          bytes_rem    = bytes_rem - 8'd1;
        end
      end
      StMrSlaAck: act.ack_next = bytes_rem > 1;
      StMrDataAck: begin
        keep_rx(d.rx_byte);
        if (bytes_rem > 1) act.ack_next = 1'b1;
        else if (bytes_rem == 0) close_msg();
      end
      StMrDataNack: begin
        keep_rx(d.rx_byte);
        close_msg();
      end
      StMtSlaNack, StMrSlaNack, StMtDataNack: begin
        chain_st      = ChainNack;
        act.send_stop = 1'b1;
        chain_idle    = 1'b1;
      end
      default: begin
        act.send_stop = 1'b1;
        chain_idle    = 1'b1;
      end
    endcase
  endfunction

  function automatic out_item_t next_bus_action(op_e op, in_item_t d);
    act = '0;
    case (op)
      OpLoad: begin
        if (d.slot < MaxMsgsDefault) begin
          tbl_addr[d.slot] = d.addr_byte;
          tbl_len[d.slot]  = d.msg_length;
          tbl_off[d.slot]  = d.msg_offset;
          tbl_set[d.slot]  = 1'b1;
        end
      end
      OpWrite: begin
        mem_buf[d.buf_index] = d.buf_byte;
        buf_set[d.buf_index] = 1'b1;
      end
      OpEnqueue: begin
        if (!bus_en) begin
          act.enqueue_result = EnqDisabled;
        end else if (!chain_idle) begin
          act.enqueue_result = EnqBusy;
        end else begin
          if (d.msg_count == 0) msgs_rem = 4'd1;
          else if (d.msg_count > MaxMsgsDefault) msgs_rem = 4'(MaxMsgsDefault);
          else msgs_rem = d.msg_count;
          slot_q = '0;
          open_msg();
          chain_idle     = 1'b0;
          chain_st       = ChainOk;
          act.send_start = 1'b1;
        end
      end
      default: take_bus_event(d);
    endcase
    act.idle         = chain_idle;
    act.chain_status = chain_st;
    return act;
  endfunction

  function automatic in_item_t ld(logic [2:0] slot, logic [7:0] addr, logic [7:0] len,
                                  logic [7:0] off);
    in_item_t d;
    d            = '0;
    d.slot       = slot;
    d.addr_byte  = addr;
    d.msg_length = len;
    d.msg_offset = off;
    return d;
  endfunction

  function automatic in_item_t wr(logic [7:0] idx, logic [7:0] val);
    in_item_t d;
    d           = '0;
    d.buf_index = idx;
    d.buf_byte  = val;
    return d;
  endfunction

  function automatic in_item_t enq(logic [3:0] cnt);
    in_item_t d;
    d           = '0;
    d.msg_count = cnt;
    return d;
  endfunction

  function automatic in_item_t ev(logic [7:0] st, logic [7:0] rx, logic wcol);
    in_item_t d;
    d                 = '0;
    d.bus_status      = st;
    d.rx_byte         = rx;
    d.write_collision = wcol;
    return d;
  endfunction

  function automatic out_item_t typed_action(logic start, logic stop, logic idl,
                                             logic [1:0] st, logic [1:0] enq_res);
    out_item_t r;
    r                = '0;
    r.send_start     = start;
    r.send_stop      = stop;
    r.idle           = idl;
    r.chain_status   = st;
    r.enqueue_result = enq_res;
    return r;
  endfunction

  function automatic void add_row(logic en, op_e op, in_item_t req, logic typed,
                                  out_item_t want);
    plan_row_t row;
    row.en    = en;
    row.op    = op;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic logic [7:0] proper_status();
    case (bus_step)
      BsStart: return $urandom_range(1) ? StStart : StRepStart;
      BsAddr:  return rd_mode ? StMrSlaAck : StMtSlaAck;
      BsData:  return StMtDataAck;
      default: return (bytes_rem > 1 || $urandom_range(5) == 0) ? StMrDataAck : StMrDataNack;
    endcase
  endfunction

  function automatic logic [7:0] any_code();
    case ($urandom_range(9))
      0: return StStart;
      1: return StRepStart;
      2: return StMtSlaAck;
      3: return StMtSlaNack;
      4: return StMtDataAck;
      5: return StMtDataNack;
      6: return StMrSlaAck;
      7: return StMrSlaNack;
      8: return StMrDataAck;
      default: return StMrDataNack;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s: got %0h expected %0h", name, got_v, want_v));
    end
  endtask

  task automatic send_req(op_e op, in_item_t d, logic typed, out_item_t want);
    out_item_t r;
    while ($urandom_range(99) < src_gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stim_count++;
    r = next_bus_action(op, d);
    pending_actions.push_back(typed ? want : r);
    if (r.send_start) begin
      bus_step = BsStart;
    end else if (op == OpEvent && r.tx_valid) begin
      if (d.bus_status == StStart || d.bus_status == StRepStart) begin
        bus_step = BsAddr;
        rd_mode  = r.tx_byte[0];
      end else begin
        bus_step = BsData;
      end
    end else if (op == OpEvent && !chain_idle &&
                 (d.bus_status == StMrSlaAck || d.bus_status == StMrDataAck)) begin
      bus_step = BsRx;
    end
  endtask

  // never let a request read a descriptor or buffer entry that was not written
  task automatic fill_reads(op_e op, in_item_t d);
    logic mt_ack;
    logic ends_msg;
    mt_ack = d.bus_status == StMtSlaAck || d.bus_status == StMtDataAck;
    if (op == OpEnqueue && bus_en && chain_idle && !tbl_set[0]) begin
      send_req(OpLoad, ld(3'd0, 8'($urandom), 8'($urandom_range(4)), 8'($urandom)),
               1'b0, '0);
    end
    if (op == OpEvent && !chain_idle && !d.write_collision) begin
      ends_msg = mt_ack ? bytes_rem == 0 :
                 d.bus_status == StMrDataAck ? bytes_rem <= 1 :
                 d.bus_status == StMrDataNack;
      if (mt_ack && bytes_rem != 0 && !buf_set[buf_pos]) begin
        send_req(OpWrite, wr(buf_pos, 8'($urandom)), 1'b0, '0);
      end
      if (ends_msg && msgs_rem > 1 && !tbl_set[slot_q + 3'd1]) begin
        send_req(OpLoad, ld(slot_q + 3'd1, 8'($urandom), 8'($urandom_range(4)),
                            8'($urandom)), 1'b0, '0);
      end
    end
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_bus_enable(logic v);
    wait_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bus_en = v;
  endtask

  task automatic random_req();
    in_item_t d;
    op_e      op;
    int       pick;
    int       n;
    d    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (chain_idle) begin
      op = pick < 20 ? OpLoad : pick < 35 ? OpWrite : pick < 92 ? OpEnqueue : OpEvent;
    end else begin
      op = pick < 92 ? OpEvent : pick < 95 ? OpLoad : pick < 98 ? OpWrite : OpEnqueue;
    end
    case (op)
      OpLoad: begin
        n = $urandom_range(99);
        d.msg_length = 8'(n < 80 ? $urandom_range(4) : n < 96 ? $urandom_range(20) :
                          n < 98 ? 8'hFF : $urandom_range(255));
      end
      OpEnqueue: begin
        n = $urandom_range(99);
        d.msg_count = 4'(n < 70 ? $urandom_range(1, 3) : n < 80 ? 0 :
                         n < 90 ? $urandom_range(9, 15) : $urandom_range(4, 8));
      end
      OpEvent: begin
        d.write_collision = 1'b0;
        if (!chain_idle && $urandom_range(99) < 88) begin
          d.bus_status = proper_status();
        end else if ($urandom_range(3) == 0) begin
          d.write_collision = 1'b1;
        end else if ($urandom_range(2) != 0) begin
          d.bus_status = any_code();
        end
      end
      default: ;
    endcase
    fill_reads(op, d);
    send_req(op, d, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", m_axis_tdata));
      end else begin
        want = pending_actions.pop_front();
        check_field("send_start", 8'(got.send_start), 8'(want.send_start));
        check_field("send_stop", 8'(got.send_stop), 8'(want.send_stop));
        check_field("ack_next", 8'(got.ack_next), 8'(want.ack_next));
        check_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
        check_field("tx_byte", got.tx_byte, want.tx_byte);
        check_field("rx_store_valid", 8'(got.rx_store_valid), 8'(want.rx_store_valid));
        check_field("rx_store_index", got.rx_store_index, want.rx_store_index);
        check_field("idle", 8'(got.idle), 8'(want.idle));
        check_field("chain_status", 8'(got.chain_status), 8'(want.chain_status));
        check_field("enqueue_result", 8'(got.enqueue_result), 8'(want.enqueue_result));
      end
    end
    m_axis_tready <= $urandom_range(99) >= sink_gap;
  end

  initial begin
    #1_000_000;
    $display("i2c_master_message_sequencer: mismatch");
    $finish;
  end

  initial begin
    // disabled bus, table and buffer setup
    add_row(1'b0, OpEvent, ev(StStart, 8'h00, 1'b0), 1'b1,
            typed_action(1'b0, 1'b0, 1'b1, ChainOk, EnqAccepted));
    add_row(1'b0, OpEnqueue, enq(4'd1), 1'b1,
            typed_action(1'b0, 1'b0, 1'b1, ChainOk, EnqDisabled));
    add_row(1'b0, OpLoad, ld(3'd0, 8'hA4, 8'd2, 8'h00), 1'b1,
            typed_action(1'b0, 1'b0, 1'b1, ChainOk, EnqAccepted));
    add_row(1'b0, OpLoad, ld(3'd1, 8'hA5, 8'd3, 8'hFE), 1'b0, '0);
    add_row(1'b0, OpWrite, wr(8'h00, 8'hFF), 1'b0, '0);
    add_row(1'b0, OpWrite, wr(8'h01, 8'h00), 1'b0, '0);
    // write message then read message wrapping the buffer pointer
    add_row(1'b1, OpEnqueue, enq(4'd2), 1'b1,
            typed_action(1'b1, 1'b0, 1'b0, ChainOk, EnqAccepted));
    add_row(1'b1, OpEnqueue, enq(4'd1), 1'b1,
            typed_action(1'b0, 1'b0, 1'b0, ChainOk, EnqBusy));
    add_row(1'b1, OpEvent, ev(StStart, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMtSlaAck, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMtDataAck, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMtDataAck, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StRepStart, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMrSlaAck, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMrDataAck, 8'h11, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMrDataAck, 8'h22, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMrDataNack, 8'h33, 1'b0), 1'b0, '0);
    // nack, write collision, unknown code, count extremes
    add_row(1'b1, OpEnqueue, enq(4'd0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StStart, 8'h00, 1'b0), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMtSlaNack, 8'h00, 1'b0), 1'b1,
            typed_action(1'b0, 1'b1, 1'b1, ChainNack, EnqAccepted));
    add_row(1'b1, OpEnqueue, enq(4'd15), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(StMtDataAck, 8'hFF, 1'b1), 1'b1,
            typed_action(1'b0, 1'b0, 1'b1, ChainWcol, EnqAccepted));
    add_row(1'b1, OpEnqueue, enq(4'd1), 1'b0, '0);
    add_row(1'b1, OpEvent, ev(8'hFF, 8'hFF, 1'b0), 1'b1,
            typed_action(1'b0, 1'b1, 1'b1, ChainOk, EnqAccepted));
    add_row(1'b1, OpLoad, ld(3'd7, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].en != bus_en) set_bus_enable(plan[i].en);
      fill_reads(plan[i].op, plan[i].req);
      send_req(plan[i].op, plan[i].req, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_gap    = ph == 0 ? 12 : ph == 1 ? 81 : 0;
      sink_gap   = ph == 0 ? 81 : ph == 1 ? 12 : 0;
      stim_count = 0;
      while (stim_count < 450) begin
        set_bus_enable($urandom_range(5) != 0);
        for (int k = 0; k < 40; k++) random_req();
      end
    end

    wait_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("i2c_master_message_sequencer: match");
    end else begin
      $display("i2c_master_message_sequencer: mismatch");
    end
    $finish;
  end

endmodule
